FILE: hdl/sector_status_run_map_assert.svh
// Assertion macros shared by the sector status map modules.
// Each use expects signals named clk and rst in the module that includes it.
`ifndef SECTOR_STATUS_RUN_MAP_ASSERT_SVH
`define SECTOR_STATUS_RUN_MAP_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define SSRM_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sector map check failed");

// Antecedent implies consequent in the same cycle.
`define SSRM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sector map check failed");

// Antecedent implies consequent in the next cycle.
`define SSRM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sector map check failed");

`endif

FILE: hdl/ssrm_pkg.sv
// Shared types and constants for the sector status run map.
// Used by ssrm_ctrl, ssrm_dp and the top level; depends on nothing.
package ssrm_pkg;

  localparam int ADDR_W = 16;
  localparam int CNT_W  = ADDR_W + 1;

  // Store depth; a larger sector count register value acts as this
  localparam logic [CNT_W-1:0] MAX_SECTORS = CNT_W'(1) << ADDR_W;

  // Status codes
  localparam logic [1:0] ST_UNTRIED = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_SAVE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_QUERY,
    S_MARK,
    S_RUN_FIRST,
    S_RUN,
    S_SAVE
  } state_t;

  // Which values the result registers take on finish
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_QUERY,
    RES_RUN
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic clear_step;
    logic mark_step;
    logic run_first;
    logic run_step;
    logic finish;
    logic clear_dirty;
    res_t res_sel;
  } dp_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic in_range;
    logic mark_go;
    logic run_match;
  } dp_stat_t;

endpackage

FILE: hdl/sector_status_run_map.sv
// Top level of the sector status run map: controller plus datapath.
// Depends on ssrm_pkg, ssrm_ctrl and ssrm_dp.
//
// After reset the block is busy while it sweeps the status store to untried,
// one sector per cycle; the sector_count register can be written during that
// time. A command is taken when start is high and busy is low, and its result
// shows on status_code, run_length and dirty for the single cycle that done is
// high; the receiver cannot stall it, so it must take every beat on that cycle.
// Query and mark saved keep busy high through one state after the accept. Mark
// range steps while sectors remain (count, cut where the range reaches the
// sector count), then finishes; run from sector takes its first sector, then
// steps while the status matches (straight to finish when the start is out of
// range). The result is on the ports in the first cycle that busy is low, and
// a new command may be accepted in that same cycle. The walks run at one
// sector per cycle, set by the single read-modify-write path through the
// status memory.

module sector_status_run_map (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [ssrm_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command,
  input  logic [ssrm_pkg::ADDR_W-1:0] sector,
  input  logic [ssrm_pkg::CNT_W-1:0]  count,
  input  logic [1:0]                  new_status,
  output logic                        done,
  output logic [1:0]                  status_code,
  output logic [ssrm_pkg::CNT_W-1:0]  run_length,
  output logic                        dirty
);

  ssrm_pkg::dp_ctrl_t ctrl;
  ssrm_pkg::dp_stat_t stat;

  ssrm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctrl    (ctrl),
    .busy    (busy)
  );

  ssrm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .sector      (sector),
    .count       (count),
    .new_status  (new_status),
    .ctrl        (ctrl),
    .stat        (stat),
    .done        (done),
    .status_code (status_code),
    .run_length  (run_length),
    .dirty       (dirty)
  );

endmodule

FILE: hdl/ssrm_dp.sv
// Datapath: status memory, address and count registers, dirty flag, result registers.
// Depends on ssrm_pkg and sector_status_run_map_assert.svh.
`include "sector_status_run_map_assert.svh"

module ssrm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ssrm_pkg::CNT_W-1:0]    cfg_data,
  input  logic [ssrm_pkg::ADDR_W-1:0]   sector,
  input  logic [ssrm_pkg::CNT_W-1:0]    count,
  input  logic [1:0]                    new_status,
  input  ssrm_pkg::dp_ctrl_t            ctrl,
  output ssrm_pkg::dp_stat_t            stat,
  output logic                          done,
  output logic [1:0]                    status_code,
  output logic [ssrm_pkg::CNT_W-1:0]    run_length,
  output logic                          dirty
);

  logic [1:0]                  mem [ssrm_pkg::MAX_SECTORS];
  logic [1:0]                  rdata;
  logic [ssrm_pkg::ADDR_W-1:0] raddr;
  logic                        we;
  logic [1:0]                  wdata;

  logic [ssrm_pkg::CNT_W-1:0]  sector_count;
  logic [ssrm_pkg::CNT_W-1:0]  limit;
  logic [ssrm_pkg::CNT_W-1:0]  addr;
  logic [ssrm_pkg::CNT_W-1:0]  addr_inc;
  logic [ssrm_pkg::CNT_W-1:0]  remaining;
  logic [ssrm_pkg::CNT_W-1:0]  run_cnt;
  logic [1:0]                  st;
  logic [1:0]                  first;
  logic                        changed;

  // Sector count register; values beyond the store act as its depth
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count <= ssrm_pkg::MAX_SECTORS;
    end else if (cfg_write) begin
      sector_count <= cfg_data;
    end
  end

  assign limit    = (sector_count > ssrm_pkg::MAX_SECTORS) ? ssrm_pkg::MAX_SECTORS
                                                           : sector_count;
  assign addr_inc = addr + ssrm_pkg::CNT_W'(1);

  // Status flags for the controller
  assign stat.in_range   = addr < limit;
  assign stat.mark_go    = stat.in_range && (remaining != '0);
  assign stat.run_match  = stat.in_range && (rdata == first);
  assign stat.clear_last = &addr[ssrm_pkg::ADDR_W-1:0];

  // Memory ports: read runs one sector ahead of addr
  assign raddr = ctrl.load ? sector : addr_inc[ssrm_pkg::ADDR_W-1:0];
  assign we    = ctrl.clear_step || (ctrl.mark_step && (rdata != st));
  assign wdata = ctrl.clear_step ? ssrm_pkg::ST_UNTRIED : st;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr[ssrm_pkg::ADDR_W-1:0]] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Address walker; also sweeps the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (ctrl.load) begin
      addr <= {1'b0, sector};
    end else if (ctrl.clear_step || ctrl.mark_step || ctrl.run_first || ctrl.run_step) begin
      addr <= addr_inc;
    end
  end

  // Item fields, run tracking
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      remaining <= count;
      st        <= (new_status == ssrm_pkg::ST_ILLEGAL) ? ssrm_pkg::ST_BAD : new_status;
    end else if (ctrl.mark_step) begin
      remaining <= remaining - ssrm_pkg::CNT_W'(1);
    end
    if (ctrl.run_first) begin
      first   <= rdata;
      run_cnt <= ssrm_pkg::CNT_W'(1);
    end else if (ctrl.run_step) begin
      run_cnt <= run_cnt + ssrm_pkg::CNT_W'(1);
    end
  end

  // Dirty flag
  always_ff @(posedge clk) begin
    if (rst) begin
      changed <= 1'b0;
    end else if (ctrl.clear_dirty) begin
      changed <= 1'b0;
    end else if (ctrl.mark_step && (rdata != st)) begin
      changed <= 1'b1;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.finish;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      dirty <= ctrl.clear_dirty ? 1'b0 : changed;
      case (ctrl.res_sel)
        ssrm_pkg::RES_QUERY: begin
          status_code <= stat.in_range ? rdata : ssrm_pkg::ST_UNTRIED;
          run_length  <= '0;
        end
        ssrm_pkg::RES_RUN: begin
          status_code <= first;
          run_length  <= run_cnt;
        end
        default: begin
          status_code <= ssrm_pkg::ST_UNTRIED;
          run_length  <= '0;
        end
      endcase
    end
  end

  `SSRM_ASSERT_NXT(a_done_single, done, !done)
  `SSRM_ASSERT_NXT(a_save_clears, ctrl.finish && ctrl.clear_dirty, !changed)
  `SSRM_ASSERT_NXT(a_change_sets, ctrl.mark_step && (rdata != st) && !ctrl.clear_dirty, changed)

endmodule

FILE: hdl/ssrm_ctrl.sv
// Controller state machine: sequences the clearing pass and each command.
// Depends on ssrm_pkg and sector_status_run_map_assert.svh.
`include "sector_status_run_map_assert.svh"

module ssrm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          command,
  input  ssrm_pkg::dp_stat_t  stat,
  output ssrm_pkg::dp_ctrl_t  ctrl,
  output logic                busy
);

  ssrm_pkg::state_t state, state_next;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssrm_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ssrm_pkg::S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next   = state;
    ctrl         = '0;
    ctrl.res_sel = ssrm_pkg::RES_ZERO;
    case (state)
      ssrm_pkg::S_CLEAR: begin
        ctrl.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = ssrm_pkg::S_IDLE;
        end
      end
      ssrm_pkg::S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          case (command)
            ssrm_pkg::CMD_QUERY: state_next = ssrm_pkg::S_QUERY;
            ssrm_pkg::CMD_MARK:  state_next = ssrm_pkg::S_MARK;
            ssrm_pkg::CMD_RUN:   state_next = ssrm_pkg::S_RUN_FIRST;
            ssrm_pkg::CMD_SAVE:  state_next = ssrm_pkg::S_SAVE;
            default:             state_next = ssrm_pkg::S_SAVE;
          endcase
        end
      end
      ssrm_pkg::S_QUERY: begin
        ctrl.finish  = 1'b1;
        ctrl.res_sel = ssrm_pkg::RES_QUERY;
        state_next   = ssrm_pkg::S_IDLE;
      end
      ssrm_pkg::S_MARK: begin
        if (stat.mark_go) begin
          ctrl.mark_step = 1'b1;
        end else begin
          ctrl.finish = 1'b1;
          state_next  = ssrm_pkg::S_IDLE;
        end
      end
      ssrm_pkg::S_RUN_FIRST: begin
        if (stat.in_range) begin
          ctrl.run_first = 1'b1;
          state_next     = ssrm_pkg::S_RUN;
        end else begin
          ctrl.finish = 1'b1;
          state_next  = ssrm_pkg::S_IDLE;
        end
      end
      ssrm_pkg::S_RUN: begin
        if (stat.run_match) begin
          ctrl.run_step = 1'b1;
        end else begin
          ctrl.finish  = 1'b1;
          ctrl.res_sel = ssrm_pkg::RES_RUN;
          state_next   = ssrm_pkg::S_IDLE;
        end
      end
      ssrm_pkg::S_SAVE: begin
        ctrl.finish      = 1'b1;
        ctrl.clear_dirty = 1'b1;
        state_next       = ssrm_pkg::S_IDLE;
      end
      default: begin
        state_next = ssrm_pkg::S_IDLE;
      end
    endcase
  end

  `SSRM_ASSERT_NXT(a_accept_busy, (state == ssrm_pkg::S_IDLE) && start, busy)
  `SSRM_ASSERT_ALWAYS(a_one_step, $onehot0({ctrl.load, ctrl.clear_step, ctrl.mark_step,
                                            ctrl.run_first, ctrl.run_step, ctrl.finish}))
  `SSRM_ASSERT_NXT(a_finish_idle, ctrl.finish, state == ssrm_pkg::S_IDLE)

endmodule

FILE: bench/sector_status_run_map_tb.sv
// Self-checking bench for sector_status_run_map: drives commands and config
// writes and checks every result beat against a shadow copy of the status map.
// Depends on ssrm_pkg and the sector_status_run_map RTL.
`timescale 1ns / 1ps

module sector_status_run_map_tb;

  localparam logic [1:0] ST_GOOD = 2'd1;
  localparam int MAP_DEPTH = 1 << ssrm_pkg::ADDR_W;
  // Longest legal stretch without a beat is the clear sweep or a full-map walk
  localparam int STALL_LIMIT = 262144;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [1:0]                 code;
    logic [ssrm_pkg::CNT_W-1:0] run;
    logic                       dirty;
  } map_result_t;

  // Shadow of the status map plus the queue of results still owed by the block
  class status_map_tracker;
    bit [1:0]                 shadow_status [MAP_DEPTH];
    bit                       shadow_dirty = 1'b0;
    bit [ssrm_pkg::CNT_W-1:0] shadow_count = ssrm_pkg::MAX_SECTORS;
    map_result_t              awaited [$];
    int                       mismatches = 0;

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    // Apply one accepted command to the shadow map and queue its result
    function void note_command(ssrm_pkg::cmd_t cmd, bit [ssrm_pkg::ADDR_W-1:0] sec,
                               bit [ssrm_pkg::CNT_W-1:0] cnt, bit [1:0] st);
      int unsigned lim;
      int unsigned s;
      int unsigned n;
      map_result_t exp_res;
      lim = 32'((shadow_count > ssrm_pkg::MAX_SECTORS) ? ssrm_pkg::MAX_SECTORS
                                                       : shadow_count);
      exp_res.code = ssrm_pkg::ST_UNTRIED;
      exp_res.run = '0;
      if (st == ssrm_pkg::ST_ILLEGAL) st = ssrm_pkg::ST_BAD;
      case (cmd)
        ssrm_pkg::CMD_QUERY: begin
          if (sec < lim) exp_res.code = shadow_status[sec];
        end
        ssrm_pkg::CMD_MARK: begin
          for (int unsigned i = 0; i < cnt; i++) begin
            s = sec + i;
            if (s >= lim) break;
            if (shadow_status[s] != st) begin
              shadow_status[s] = st;
              shadow_dirty = 1'b1;
            end
          end
        end
        ssrm_pkg::CMD_RUN: begin
          if (sec < lim) begin
            n = 1;
            while (sec + n < lim && shadow_status[sec + n] == shadow_status[sec]) n++;
            exp_res.code = shadow_status[sec];
            exp_res.run = ssrm_pkg::CNT_W'(n);
          end
        end
        default: shadow_dirty = 1'b0;
      endcase
      exp_res.dirty = shadow_dirty;
      awaited.push_back(exp_res);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(logic [1:0] code, logic [ssrm_pkg::CNT_W-1:0] run,
                               logic dirty);
      map_result_t exp_res;
      if (awaited.size() == 0) begin
        flag($sformatf("result beat with nothing expected (code %0d run %0d dirty %0d)",
                       code, run, dirty));
        return;
      end
      exp_res = awaited.pop_front();
      if (code !== exp_res.code)
        flag($sformatf("status_code exp %0d got %0d", exp_res.code, code));
      if (run !== exp_res.run)
        flag($sformatf("run_length exp %0d got %0d", exp_res.run, run));
      if (dirty !== exp_res.dirty)
        flag($sformatf("dirty exp %0d got %0d", exp_res.dirty, dirty));
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        cfg_write;
  logic [ssrm_pkg::CNT_W-1:0]  cfg_data;
  logic                        start;
  logic                        busy;
  logic [1:0]                  command;
  logic [ssrm_pkg::ADDR_W-1:0] sector;
  logic [ssrm_pkg::CNT_W-1:0]  count;
  logic [1:0]                  new_status;
  logic                        done;
  logic [1:0]                  status_code;
  logic [ssrm_pkg::CNT_W-1:0]  run_length;
  logic                        dirty;

  status_map_tracker tracker;
  int                sender_idle_pct = 0;
  int                stall_cycles = 0;

  sector_status_run_map u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .sector      (sector),
    .count       (count),
    .new_status  (new_status),
    .done        (done),
    .status_code (status_code),
    .run_length  (run_length),
    .dirty       (dirty)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor: config writes, accepted commands and result beats
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) tracker.shadow_count = cfg_data;
      if (done) tracker.check_result(status_code, run_length, dirty);
      if (start && !busy)
        tracker.note_command(ssrm_pkg::cmd_t'(command), sector, count, new_status);
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("[%0t] no beat for %0d cycles", $time, STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Present one command beat; returns just after the edge that took it,
  // with start still high so the next caller acts at the coming falling edge
  task automatic issue(ssrm_pkg::cmd_t cmd, logic [ssrm_pkg::ADDR_W-1:0] sec,
                       logic [ssrm_pkg::CNT_W-1:0] cnt, logic [1:0] st);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    sector <= sec;
    count <= cnt;
    new_status <= st;
    do @(posedge clk); while (busy);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk);
  endtask

  task automatic set_sector_count(logic [ssrm_pkg::CNT_W-1:0] val);
    drain();
    cfg_data <= val;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned lim;
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    logic [ssrm_pkg::CNT_W-1:0] sc_val;
    logic [ssrm_pkg::ADDR_W-1:0] sec;
    logic [ssrm_pkg::CNT_W-1:0] cnt;
    ssrm_pkg::cmd_t cmd;

    tracker = new;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    start = 1'b0;
    command = ssrm_pkg::CMD_QUERY;
    sector = '0;
    count = '0;
    new_status = ssrm_pkg::ST_UNTRIED;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: full-map walks, clipping at the map end, status three, dirty rules
    issue(ssrm_pkg::CMD_QUERY, 16'h0000, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_QUERY, 16'hFFFF, 17'h1FFFF, ssrm_pkg::ST_ILLEGAL);
    issue(ssrm_pkg::CMD_RUN, 16'h0000, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_MARK, 16'h0000, 17'd65536, ST_GOOD);
    issue(ssrm_pkg::CMD_SAVE, 16'h0000, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_MARK, 16'd100, 17'd0, ssrm_pkg::ST_BAD);
    issue(ssrm_pkg::CMD_MARK, 16'd10, 17'd5, ssrm_pkg::ST_ILLEGAL);
    issue(ssrm_pkg::CMD_RUN, 16'd0, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_RUN, 16'd10, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_QUERY, 16'd12, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_SAVE, 16'd0, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_MARK, 16'd10, 17'd3, ssrm_pkg::ST_BAD);
    issue(ssrm_pkg::CMD_MARK, 16'hFFF0, 17'h1FFFF, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_RUN, 16'hFFF0, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_RUN, 16'hFFFF, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_QUERY, 16'hFFFF, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_MARK, 16'd15, 17'd1, ssrm_pkg::ST_UNTRIED);
    // Empty map: everything reads out of range
    set_sector_count(17'd0);
    issue(ssrm_pkg::CMD_QUERY, 16'd5, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_RUN, 16'd0, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_MARK, 16'd0, 17'd10, ST_GOOD);
    issue(ssrm_pkg::CMD_SAVE, 16'd0, 17'd0, ssrm_pkg::ST_UNTRIED);
    // Register above the store depth acts as the full map
    set_sector_count(17'h1FFFF);
    issue(ssrm_pkg::CMD_RUN, 16'hFFF8, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_QUERY, 16'd15, 17'd0, ssrm_pkg::ST_UNTRIED);
    set_sector_count(17'd1);
    issue(ssrm_pkg::CMD_RUN, 16'd0, 17'd0, ssrm_pkg::ST_UNTRIED);
    issue(ssrm_pkg::CMD_QUERY, 16'd1, 17'd0, ssrm_pkg::ST_UNTRIED);

    // Random: three idle profiles, four map sizes each
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 60 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        case (seg)
          0: sc_val = 17'($urandom_range(1, 64));
          1: sc_val = 17'($urandom_range(1, 300));
          2: begin
            pick = $urandom_range(2);
            sc_val = (pick == 0) ? 17'd65536 : (pick == 1) ? 17'h1FFFF :
                     17'($urandom_range(513, 17'h1FFFF));
          end
          default: sc_val = 17'($urandom_range(1, 16));
        endcase
        set_sector_count(sc_val);
        lim = 32'((sc_val > ssrm_pkg::MAX_SECTORS) ? ssrm_pkg::MAX_SECTORS : sc_val);
        for (int k = 0; k < 71; k++) begin
          pick = $urandom_range(99);
          cmd = (pick < 25) ? ssrm_pkg::CMD_QUERY : (pick < 60) ? ssrm_pkg::CMD_MARK :
                (pick < 90) ? ssrm_pkg::CMD_RUN : ssrm_pkg::CMD_SAVE;
          cnt = 17'($urandom_range(0, 17'h1FFFF));
          if (lim <= 512) begin
            // Small map: mostly inside it, some anywhere; long marks get clipped
            if ($urandom_range(99) < 80) sec = 16'($urandom_range(0, lim + 8));
            else sec = 16'($urandom);
            if (cmd == ssrm_pkg::CMD_MARK && $urandom_range(99) < 70)
              cnt = 17'($urandom_range(0, 2 * lim + 2));
          end else begin
            // Large map: keep walks short, runs start near the map end
            sec = 16'($urandom);
            if (cmd == ssrm_pkg::CMD_MARK) cnt = 17'($urandom_range(0, 40));
            if (cmd == ssrm_pkg::CMD_RUN) begin
              lo = (lim > 48) ? lim - 48 : 0;
              hi = (lim + 4 > 65535) ? 65535 : lim + 4;
              sec = 16'($urandom_range(lo, hi));
            end
          end
          issue(cmd, sec, cnt, 2'($urandom_range(0, 3)));
        end
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (tracker.awaited.size() != 0)
      tracker.flag($sformatf("%0d results never arrived", tracker.awaited.size()));
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
